### hw/rtl/xrg_pkg.sv
package xrg_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned FUNC_W = 2;
    localparam int unsigned WARMUP_STEPS_DEF = 16;

    localparam logic [WORD_W-1:0] GOLDEN    = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam logic [WORD_W-1:0] DEF_FIRST  = 64'h0123456789abcdef;
    localparam logic [WORD_W-1:0] DEF_SECOND = 64'hfedcba9876543210;
    localparam logic [HALF_W-1:0] MAX32 = 32'hffffffff;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SEED   = 2'd0,
        FUNC_DRAW64 = 2'd1,
        FUNC_DRAW32 = 2'd2,
        FUNC_RANGE  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_MIX_A,
        ST_MUL_A,
        ST_MIX_B,
        ST_MUL_B,
        ST_ZCHK,
        ST_WARM,
        ST_DRAW,
        ST_RANGE,
        ST_LIM,
        ST_RDRAW,
        ST_RMOD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [HALF_W-1:0] num;
        logic [HALF_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [HALF_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [2*WORD_W-1:0] xs_advance(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        logic [WORD_W-1:0] t;
        t = b ^ (b << 23);
        t = t ^ (t >> 17);
        t = t ^ a ^ (a >> 26);
        return {b, t};
    endfunction

endpackage

### hw/rtl/xrg_mul.sv
module xrg_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  xrg_pkg::mul_req_t req,
    output xrg_pkg::mul_rsp_t rsp
);
    import xrg_pkg::*;

    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [1:0]        step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [HALF_W-1:0] op_a, op_b;

    // low 64 bits of a 64x64 product from three 32x32 partial products
    always_comb begin
        op_a = (step_reg == 2'd2) ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        op_b = (step_reg == 2'd1) ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            step_next = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prod_next = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
            unique case (step_reg)
                2'd0: acc_next = acc_reg;
                2'd1: acc_next = acc_reg + prod_reg;
                default: acc_next = acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
            endcase
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        step_reg <= step_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

### hw/rtl/xrg_div.sv
module xrg_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  xrg_pkg::div_req_t req,
    output xrg_pkg::div_rsp_t rsp
);
    import xrg_pkg::*;

    localparam int unsigned CNT_W = $clog2(HALF_W);

    logic [HALF_W-1:0] n_reg, n_next;
    logic [HALF_W-1:0] d_reg, d_next;
    logic [HALF_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [HALF_W:0]   trial;

    // restoring remainder, one bit per cycle
    always_comb begin
        trial     = {rem_reg, n_reg[HALF_W-1]};
        n_next    = n_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            n_next    = req.num;
            d_next    = req.den;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                rem_next = HALF_W'(trial - {1'b0, d_reg});
            end else begin
                rem_next = trial[HALF_W-1:0];
            end
            n_next   = {n_reg[HALF_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(HALF_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

### hw/rtl/xorshift_random_generator_core.sv
// xorshift128+ generator with splitmix64 seeding. One beat in, one beat out;
// s_tready is high only while the core is idle. Seeding runs through the
// shared 32x32 multiplier doing two 64-bit products per splitmix step, then
// WARMUP_STEPS generator advances. Range first computes the rejection limit
// (serial remainder unit, one bit per cycle), then draws 32-bit values until
// one is below the limit and adds its remainder by the span to range_low;
// a single-value or inverted range returns range_low directly.
module xorshift_random_generator_core #(
    parameter int unsigned WARMUP_STEPS = xrg_pkg::WARMUP_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // seed_value, range_low, range_high
    input  logic [1:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // value
    output logic         m_tuser    // was_seeded
);
    import xrg_pkg::*;

    localparam int unsigned WCNT_W = $clog2(WARMUP_STEPS + 2);

    state_t state_reg, state_next;

    logic [WORD_W-1:0] w1_reg, w1_next;
    logic [WORD_W-1:0] w2_reg, w2_next;
    logic              seeded_reg, seeded_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] z_reg, z_next;
    logic              mix_idx_reg, mix_idx_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;
    func_t             func_reg, func_next;
    logic [HALF_W-1:0] lo_reg, lo_next;
    logic [HALF_W-1:0] hi_reg, hi_next;
    logic [HALF_W-1:0] span_reg, span_next;
    logic [HALF_W-1:0] limit_reg, limit_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              ovalid_reg, ovalid_next;
    logic [WORD_W-1:0] odata_reg, odata_next;
    logic              ouser_reg, ouser_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [2*WORD_W-1:0] adv;
    logic [WORD_W-1:0]   sum;
    logic [WORD_W-1:0]   mixed;
    logic [HALF_W-1:0]   span_calc;
    logic                out_free;

    xrg_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req), .rsp(mul_rsp));
    xrg_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    assign adv       = xs_advance(w1_reg, w2_reg);
    assign sum       = w1_reg + w2_reg;
    assign mixed     = mul_rsp.prod ^ (mul_rsp.prod >> 31);
    assign span_calc = hi_reg - lo_reg + 1'b1;
    assign out_free  = !ovalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (func_t'(s_tuser))
                        FUNC_SEED:  state_next = ST_SEED;
                        FUNC_RANGE: state_next = ST_RANGE;
                        default:    state_next = ST_DRAW;
                    endcase
                end
            end
            ST_SEED:  state_next = ST_MIX_A;
            ST_MIX_A: state_next = ST_MUL_A;
            ST_MUL_A: if (mul_rsp.done) state_next = ST_MIX_B;
            ST_MIX_B: state_next = ST_MUL_B;
            ST_MUL_B: begin
                if (mul_rsp.done) state_next = mix_idx_reg ? ST_ZCHK : ST_MIX_A;
            end
            ST_ZCHK:  state_next = (WARMUP_STEPS == 0) ? ST_DONE : ST_WARM;
            ST_WARM: begin
                if (wcnt_reg == WCNT_W'(WARMUP_STEPS - 1)) state_next = ST_DONE;
            end
            ST_DRAW:  state_next = ST_DONE;
            ST_RANGE: begin
                if (lo_reg >= hi_reg) begin
                    state_next = ST_DONE;
                end else if (span_calc == '0) begin
                    state_next = ST_DRAW;
                end else begin
                    state_next = ST_LIM;
                end
            end
            ST_LIM:   if (div_rsp.done) state_next = ST_RDRAW;
            ST_RDRAW: if (sum[HALF_W-1:0] < limit_reg) state_next = ST_RMOD;
            ST_RMOD:  if (div_rsp.done) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        w1_next      = w1_reg;
        w2_next      = w2_reg;
        seeded_next  = seeded_reg;
        acc_next     = acc_reg;
        z_next       = z_reg;
        mix_idx_next = mix_idx_reg;
        wcnt_next    = wcnt_reg;
        func_next    = func_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        span_next    = span_reg;
        limit_next   = limit_reg;
        res_next     = res_reg;
        odata_next   = odata_reg;
        ouser_next   = ouser_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        mul_req      = '0;
        div_req      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next = func_t'(s_tuser);
                    acc_next  = s_tdata[63:0];
                    lo_next   = s_tdata[95:64];
                    hi_next   = s_tdata[127:96];
                end
            end
            ST_SEED: begin
                acc_next     = acc_reg + GOLDEN;
                mix_idx_next = 1'b0;
            end
            ST_MIX_A: begin
                mul_req.start = 1'b1;
                mul_req.a     = acc_reg ^ (acc_reg >> 30);
                mul_req.b     = MIX_MUL_A;
            end
            ST_MUL_A: if (mul_rsp.done) z_next = mul_rsp.prod;
            ST_MIX_B: begin
                mul_req.start = 1'b1;
                mul_req.a     = z_reg ^ (z_reg >> 27);
                mul_req.b     = MIX_MUL_B;
            end
            ST_MUL_B: begin
                if (mul_rsp.done) begin
                    if (mix_idx_reg) begin
                        w2_next = mixed;
                    end else begin
                        w1_next      = mixed;
                        acc_next     = acc_reg + GOLDEN;
                        mix_idx_next = 1'b1;
                    end
                end
            end
            ST_ZCHK: begin
                if (w1_reg == '0 && w2_reg == '0) begin
                    w1_next = DEF_FIRST;
                    w2_next = DEF_SECOND;
                end
                seeded_next = 1'b1;
                wcnt_next   = '0;
                res_next    = '0;
            end
            ST_WARM: begin
                {w1_next, w2_next} = adv;
                wcnt_next = wcnt_reg + 1'b1;
            end
            ST_DRAW: begin
                {w1_next, w2_next} = adv;
                res_next = (func_reg == FUNC_DRAW64) ? sum
                         : {{HALF_W{1'b0}}, sum[HALF_W-1:0]};
            end
            ST_RANGE: begin
                span_next = span_calc;
                res_next  = {{HALF_W{1'b0}}, lo_reg};
                if (lo_reg < hi_reg && span_calc != '0) begin
                    div_req.start = 1'b1;
                    div_req.num   = MAX32;
                    div_req.den   = span_calc;
                end
            end
            ST_LIM: if (div_rsp.done) limit_next = MAX32 - div_rsp.rem;
            ST_RDRAW: begin
                {w1_next, w2_next} = adv;
                if (sum[HALF_W-1:0] < limit_reg) begin
                    div_req.start = 1'b1;
                    div_req.num   = sum[HALF_W-1:0];
                    div_req.den   = span_reg;
                end
            end
            ST_RMOD: begin
                if (div_rsp.done) res_next = {{HALF_W{1'b0}}, lo_reg + div_rsp.rem};
            end
            ST_DONE: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    odata_next  = res_reg;
                    ouser_next  = seeded_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        z_reg     <= z_next;
        wcnt_reg  <= wcnt_next;
        func_reg  <= func_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        span_reg  <= span_next;
        limit_reg <= limit_next;
        res_reg   <= res_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            w1_reg      <= DEF_FIRST;
            w2_reg      <= DEF_SECOND;
            seeded_reg  <= 1'b0;
            mix_idx_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            w1_reg      <= w1_next;
            w2_reg      <= w2_next;
            seeded_reg  <= seeded_next;
            mix_idx_reg <= mix_idx_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

endmodule
